/* design/tfsl_pkg.sv */
package tfsl_pkg;

  // Field widths of the word on each channel.
  localparam int unsigned TempW   = 19;
  localparam int unsigned ThrW    = 18;
  localparam int unsigned PctW    = 7;
  localparam int unsigned MaskW   = 5;
  localparam int unsigned CfgIdxW = 3;

  // Default number of fans whose failure bits count.
  localparam int unsigned NumFansDef = 5;

  // Duty steps of the ladders.
  localparam logic [PctW-1:0] PctFull = 7'd100;
  localparam logic [PctW-1:0] PctHigh = 7'd80;
  localparam logic [PctW-1:0] PctMid  = 7'd65;
  localparam logic [PctW-1:0] PctLow  = 7'd40;

  // Threshold reset values in millidegrees.
  localparam logic [ThrW-1:0] RiseFullRst = 18'd57500;
  localparam logic [ThrW-1:0] RiseHighRst = 18'd53000;
  localparam logic [ThrW-1:0] RiseMidRst  = 18'd49500;
  localparam logic [ThrW-1:0] FallHighRst = 18'd52700;
  localparam logic [ThrW-1:0] FallMidRst  = 18'd47700;
  localparam logic [ThrW-1:0] FallLowRst  = 18'd42700;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegRiseFull = 3'd0,
    RegRiseHigh = 3'd1,
    RegRiseMid  = 3'd2,
    RegFallHigh = 3'd3,
    RegFallMid  = 3'd4,
    RegFallLow  = 3'd5
  } cfg_idx_e;

  // All six thresholds as one bundle.
  typedef struct packed {
    logic [ThrW-1:0] rise_full;
    logic [ThrW-1:0] rise_high;
    logic [ThrW-1:0] rise_mid;
    logic [ThrW-1:0] fall_high;
    logic [ThrW-1:0] fall_mid;
    logic [ThrW-1:0] fall_low;
  } thr_t;

  // Stored state seen by the decision logic.
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PctW-1:0]         pct;
  } fan_state_t;

  // Outcome of one reading set.
  typedef struct packed {
    logic                    emit;
    logic [PctW-1:0]         pct;
    logic signed [TempW-1:0] avg;
  } decision_t;

endpackage

/* design/thermal_fan_speed_ladder_core.sv */
// Fan speed controller driven by pairs of temperature readings.
//
// Input channel: in_valid_i with the two sensor readings, the failed-fan mask
// and a readings-valid flag; a word is taken when in_valid_i is high and
// in_stall_o is low. Output channel: out_valid_o with fan_percent_o; a word
// leaves when out_valid_o is high and out_stall_i is low. A reading set
// produces a word only when it changes the fan speed.
//
// A word passes from the input register through the averaging and ladder
// compare to the result register, which drives out_valid_o and also
// updates the stored temperature and speed. One word is taken every cycle
// unless a result word waits on a stalled receiver; the state feedback
// around the result register sets that rate. While the receiver stalls,
// the result register holds its word, the input register still takes one
// more word, and words that cause no result keep draining through. At
// reset the thresholds return to their defaults, the stored temperature and
// speed clear to zero, and both channels go empty. Configuration writes are
// registered and must be made while no word is in flight.
module thermal_fan_speed_ladder_core
  import tfsl_pkg::*;
#(
  parameter int unsigned NUM_FANS = NumFansDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ThrW-1:0]         cfg_data_i,
  // Input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [TempW-1:0] sensor_a_millideg_i,
  input  logic signed [TempW-1:0] sensor_b_millideg_i,
  input  logic [MaskW-1:0]        fan_failed_mask_i,
  input  logic                    readings_valid_i,
  // Output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PctW-1:0]         fan_percent_o
);

  thr_t                    thr_q;
  logic                    s1_vld_q;
  logic signed [TempW-1:0] s1_a_q;
  logic signed [TempW-1:0] s1_b_q;
  logic [MaskW-1:0]        s1_mask_q;
  logic [MaskW-1:0]        fan_en;
  logic                    fan_fail;
  fan_state_t              state_q;
  decision_t               dec;
  logic                    out_vld_q;
  logic [PctW-1:0]         out_pct_q;
  logic                    out_free;
  logic                    s1_adv;
  logic                    in_acc;
  logic                    load_out;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.rise_full <= RiseFullRst;
      thr_q.rise_high <= RiseHighRst;
      thr_q.rise_mid  <= RiseMidRst;
      thr_q.fall_high <= FallHighRst;
      thr_q.fall_mid  <= FallMidRst;
      thr_q.fall_low  <= FallLowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRiseFull: thr_q.rise_full <= cfg_data_i;
        RegRiseHigh: thr_q.rise_high <= cfg_data_i;
        RegRiseMid:  thr_q.rise_mid  <= cfg_data_i;
        RegFallHigh: thr_q.fall_high <= cfg_data_i;
        RegFallMid:  thr_q.fall_mid  <= cfg_data_i;
        RegFallLow:  thr_q.fall_low  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when its word makes no result
  // or when the result register can take one.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_adv     = s1_vld_q && (out_free || !dec.emit);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_out   = s1_vld_q && dec.emit && out_free;

  // Input register; invalid readings are taken and dropped here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= readings_valid_i;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_a_q    <= sensor_a_millideg_i;
      s1_b_q    <= sensor_b_millideg_i;
      s1_mask_q <= fan_failed_mask_i;
    end
  end

  // Only the fans that are fitted count toward a failure.
  for (genvar i = 0; i < MaskW; i++) begin : g_fan_en
    assign fan_en[i] = (i < NUM_FANS);
  end
  assign fan_fail = |(s1_mask_q & fan_en);

  tfsl_ladder u_ladder (
    .sensor_a_i (s1_a_q),
    .sensor_b_i (s1_b_q),
    .fan_fail_i (fan_fail),
    .state_i    (state_q),
    .thr_i      (thr_q),
    .dec_o      (dec)
  );

  // Stored state and result register update together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.temp <= '0;
      state_q.pct  <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (load_out) begin
        state_q.temp <= dec.avg;
        state_q.pct  <= dec.pct;
        out_vld_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pct_q <= dec.pct;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign fan_percent_o = out_pct_q;

  // A pending word always carries one of the ladder steps.
  a_pct_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_pct_q == PctFull || out_pct_q == PctHigh ||
                   out_pct_q == PctMid || out_pct_q == PctLow))
    else $error("result word is not a ladder step");

  // The stored speed tracks the last word sent.
  a_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (state_q.pct == out_pct_q))
    else $error("stored speed differs from result word");

  // A result is never loaded over a stalled pending word.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !load_out)
    else $error("result register overwritten while stalled");

  // The input only stalls behind a word that waits for the result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && dec.emit && out_vld_q))
    else $error("input stalled without a blocked result");

endmodule

/* design/tfsl_ladder.sv */
module tfsl_ladder
  import tfsl_pkg::*;
(
  input  logic signed [TempW-1:0] sensor_a_i,
  input  logic signed [TempW-1:0] sensor_b_i,
  input  logic                    fan_fail_i,
  input  fan_state_t              state_i,
  input  thr_t                    thr_i,
  output decision_t               dec_o
);

  logic signed [TempW:0]   sum;
  logic signed [TempW:0]   sum_adj;
  logic signed [TempW-1:0] avg;
  logic [PctW-1:0]         rise_pct;
  logic [PctW-1:0]         fall_pct;
  logic [PctW-1:0]         pct;
  logic                    active;

  // Average of the two readings, rounded toward zero.
  assign sum     = {sensor_a_i[TempW-1], sensor_a_i} + {sensor_b_i[TempW-1], sensor_b_i};
  assign sum_adj = sum + {{TempW{1'b0}}, sum[TempW]};
  assign avg     = sum_adj[TempW:1];

  // Rising ladder, tested from the top step down.
  always_comb begin
    priority if (avg >= $signed({1'b0, thr_i.rise_full})) begin
      rise_pct = PctFull;
    end else if (avg >= $signed({1'b0, thr_i.rise_high})) begin
      rise_pct = PctHigh;
    end else if (avg >= $signed({1'b0, thr_i.rise_mid})) begin
      rise_pct = PctMid;
    end else begin
      rise_pct = PctLow;
    end
  end

  // Falling ladder, tested from the bottom step up.
  always_comb begin
    priority if (avg <= $signed({1'b0, thr_i.fall_low})) begin
      fall_pct = PctLow;
    end else if (avg <= $signed({1'b0, thr_i.fall_mid})) begin
      fall_pct = PctMid;
    end else if (avg <= $signed({1'b0, thr_i.fall_high})) begin
      fall_pct = PctHigh;
    end else begin
      fall_pct = PctFull;
    end
  end

  // A failed fan forces full speed; an unchanged average does nothing.
  always_comb begin
    priority if (fan_fail_i) begin
      active = 1'b1;
      pct    = PctFull;
    end else if (avg == state_i.temp) begin
      active = 1'b0;
      pct    = state_i.pct;
    end else if (avg > state_i.temp) begin
      active = 1'b1;
      pct    = rise_pct;
    end else begin
      active = 1'b1;
      pct    = fall_pct;
    end
  end

  assign dec_o.emit = active && (pct != state_i.pct);
  assign dec_o.pct  = pct;
  assign dec_o.avg  = avg;

endmodule
